FILE: hdl/lpbp_pkg.sv
package lpbp_pkg;

	localparam int POINTS_PER_BLOCK = 32;
	localparam int PT_CNT_W = (POINTS_PER_BLOCK > 1) ? $clog2(POINTS_PER_BLOCK) : 1;
	localparam logic [PT_CNT_W-1:0] PT_LAST = PT_CNT_W'(POINTS_PER_BLOCK - 1);

	localparam logic [7:0] SYNC_FIRST   = 8'hFF;
	localparam logic [7:0] SYNC_SECOND  = 8'hEE;
	localparam logic [7:0] GPS_FIRST    = 8'h24;	// '$'
	localparam logic [7:0] GPS_SECOND   = 8'h47;	// 'G'
	localparam logic [7:0] BLK_CNT_MAX  = 8'hFF;

	localparam logic [7:0] BLOCKS_RESET = 8'd12;
	localparam logic [7:0] GPS_LEN_RESET = 8'd84;

	localparam int ADDR_W = 3;
	localparam logic REG_BLOCKS  = 1'b0;
	localparam logic REG_GPS_LEN = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_AZIMUTH,
		PH_POINTS,
		PH_TIMESTAMP,
		PH_GPS
	} phase_t;

	typedef enum logic [2:0] {
		KIND_AZIMUTH,
		KIND_DISTANCE,
		KIND_REFLECT,
		KIND_TIMESTAMP,
		KIND_GPS_START,
		KIND_GPS_CHAR
	} kind_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [31:0] value;
		logic [4:0]  point_index;
	} result_t;

endpackage

FILE: hdl/lpbp_core.sv
module lpbp_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            data_byte,
	input  logic [7:0]            blocks_per_packet,
	input  logic [7:0]            gps_sentence_length,
	output lpbp_pkg::result_t     res
);

	lpbp_pkg::phase_t phase_q, phase_d;
	logic [7:0]  prev_q, prev_d;
	logic        prev_idle_q, prev_idle_d;
	logic [lpbp_pkg::PT_CNT_W-1:0] pt_q, pt_d;
	logic [2:0]  sub_q, sub_d;
	logic [31:0] acc_q, acc_d;
	logic [7:0]  blk_q, blk_d;
	logic [7:0]  gps_rem_q, gps_rem_d;
	logic        was_idle;
	logic [15:0] dist_le;
	logic [lpbp_pkg::PT_CNT_W+4:0] pt_wide;

	assign dist_le = {data_byte, acc_q[7:0]};
	assign pt_wide = {5'b0, pt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= lpbp_pkg::PH_IDLE;
			prev_q      <= '0;
			prev_idle_q <= 1'b0;
			pt_q        <= '0;
			sub_q       <= '0;
			acc_q       <= '0;
			blk_q       <= '0;
			gps_rem_q   <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			prev_q      <= prev_d;
			prev_idle_q <= prev_idle_d;
			pt_q        <= pt_d;
			sub_q       <= sub_d;
			acc_q       <= acc_d;
			blk_q       <= blk_d;
			gps_rem_q   <= gps_rem_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		prev_d      = data_byte;
		pt_d        = pt_q;
		sub_d       = sub_q;
		acc_d       = acc_q;
		blk_d       = blk_q;
		gps_rem_d   = gps_rem_q;
		was_idle    = 1'b0;
		res.valid       = 1'b0;
		res.kind        = lpbp_pkg::KIND_AZIMUTH;
		res.value       = '0;
		res.point_index = '0;

		case (phase_q)
			lpbp_pkg::PH_AZIMUTH: begin
				if (sub_q == 3'd0) begin
					acc_d = {24'b0, data_byte};
					sub_d = 3'd1;
				end else begin
					res.valid = 1'b1;
					res.kind  = lpbp_pkg::KIND_AZIMUTH;
					res.value = {16'b0, dist_le};
					sub_d     = 3'd0;
					pt_d      = '0;
					phase_d   = lpbp_pkg::PH_POINTS;
				end
			end
			lpbp_pkg::PH_POINTS: begin
				case (sub_q)
					3'd0: begin
						acc_d = {24'b0, data_byte};
						sub_d = 3'd1;
					end
					3'd1: begin
						res.valid       = 1'b1;
						res.kind        = lpbp_pkg::KIND_DISTANCE;
						res.value       = {15'b0, dist_le, 1'b0};
						res.point_index = pt_wide[4:0];
						sub_d           = 3'd2;
					end
					default: begin
						res.valid       = 1'b1;
						res.kind        = lpbp_pkg::KIND_REFLECT;
						res.value       = {24'b0, data_byte};
						res.point_index = pt_wide[4:0];
						sub_d           = 3'd0;
						if (pt_q == lpbp_pkg::PT_LAST) begin
							pt_d    = '0;
							phase_d = (blk_q == blocks_per_packet) ?
								lpbp_pkg::PH_TIMESTAMP : lpbp_pkg::PH_IDLE;
						end else begin
							pt_d = pt_q + 1'b1;
						end
					end
				endcase
			end
			lpbp_pkg::PH_TIMESTAMP: begin
				if (sub_q[2] == 1'b0) begin
					// little-endian assembly, first byte clears the word
					if (sub_q[1:0] == 2'd0)
						acc_d = {24'b0, data_byte};
					else
						acc_d[8*sub_q[1:0] +: 8] = data_byte;
					sub_d = sub_q + 3'd1;
				end else begin
					// fifth byte is dropped, timestamp goes out here
					res.valid = 1'b1;
					res.kind  = lpbp_pkg::KIND_TIMESTAMP;
					res.value = acc_q;
					sub_d     = 3'd0;
					blk_d     = '0;
					phase_d   = lpbp_pkg::PH_IDLE;
				end
			end
			lpbp_pkg::PH_GPS: begin
				if (gps_rem_q != 8'd0) begin
					res.valid = 1'b1;
					res.kind  = lpbp_pkg::KIND_GPS_CHAR;
					res.value = {24'b0, data_byte};
					gps_rem_d = gps_rem_q - 8'd1;
				end else begin
					phase_d = lpbp_pkg::PH_IDLE;
				end
			end
			default: begin
				was_idle = 1'b1;
				phase_d  = lpbp_pkg::PH_IDLE;
				if (prev_idle_q && prev_q == lpbp_pkg::SYNC_FIRST &&
				    data_byte == lpbp_pkg::SYNC_SECOND) begin
					phase_d = lpbp_pkg::PH_AZIMUTH;
					sub_d   = 3'd0;
					if (blk_q != lpbp_pkg::BLK_CNT_MAX)
						blk_d = blk_q + 8'd1;
				end else if (prev_idle_q && prev_q == lpbp_pkg::GPS_FIRST &&
				             data_byte == lpbp_pkg::GPS_SECOND) begin
					phase_d   = lpbp_pkg::PH_GPS;
					gps_rem_d = gps_sentence_length;
					res.valid = 1'b1;
					res.kind  = lpbp_pkg::KIND_GPS_START;
				end
			end
		endcase

		prev_idle_d = was_idle;
	end

endmodule

FILE: hdl/lidar_packet_byte_parser.sv
// Lidar byte-stream parser: takes one raw byte per request on data_byte and
// returns zero or one result per byte (azimuth, doubled distance, reflectivity,
// timestamp, GPS start, GPS character) on kind/value/point_index. Parser
// state is updated in the accept cycle and the result lands in an output
// register, so a byte can be accepted every cycle as long as the output
// register is empty or being drained. A sync pair (0xFF,0xEE or
// '$','G') is only recognized when both bytes arrive while the parser is idle.
// Registers: 0x0 blocks_per_packet (reset 12), 0x4 gps_sentence_length
// (reset 84); write them only while the parser is idle.
module lidar_packet_byte_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    kind,
	output logic [31:0]                   value,
	output logic [4:0]                    point_index,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lpbp_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [7:0] blocks_q;
	logic [7:0] gps_len_q;
	logic       cfg_wr;
	logic       accept;
	lpbp_pkg::result_t res;
	logic        out_valid_q;
	lpbp_pkg::kind_t kind_q;
	logic [31:0] value_q;
	logic [4:0]  point_q;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_q  <= lpbp_pkg::BLOCKS_RESET;
			gps_len_q <= lpbp_pkg::GPS_LEN_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				lpbp_pkg::REG_BLOCKS:  blocks_q  <= pwdata[7:0];
				lpbp_pkg::REG_GPS_LEN: gps_len_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			lpbp_pkg::REG_BLOCKS:  prdata = {24'b0, blocks_q};
			lpbp_pkg::REG_GPS_LEN: prdata = {24'b0, gps_len_q};
			default:               prdata = '0;
		endcase
	end

	// the output register frees up in the same cycle it is drained
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	lpbp_core u_core (
		.clk                 (clk),
		.arst_n              (arst_n),
		.accept              (accept),
		.data_byte           (data_byte),
		.blocks_per_packet   (blocks_q),
		.gps_sentence_length (gps_len_q),
		.res                 (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= accept && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res.valid) begin
			kind_q  <= res.kind;
			value_q <= res.value;
			point_q <= res.point_index;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign value       = value_q;
	assign point_index = point_q;

endmodule
